/* hdl/alfl_pkg.sv */
// alfl_pkg: shared types and codes for the array linked list with free list
// request and response word structs, opcodes, status codes and control states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package alfl_pkg;

	typedef struct packed {
		logic [2:0] opcode;
		logic [6:0] position;
		logic [5:0] node_index;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] node;
	} rsp_t;

	localparam logic [2:0] OP_INS_TAIL = 3'd0;
	localparam logic [2:0] OP_INS_POS  = 3'd1;
	localparam logic [2:0] OP_INS_IDX  = 3'd2;
	localparam logic [2:0] OP_REM_TAIL = 3'd3;
	localparam logic [2:0] OP_REM_POS  = 3'd4;
	localparam logic [2:0] OP_REM_IDX  = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BADPOS   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_WRITE1,
		S_WRITE2,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

/* hdl/alfl_link_mem.sv */
// alfl_link_mem: next-link store, one write port and one read port
// read data is registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module alfl_link_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 7
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* hdl/array_linked_list_with_free_list.sv */
// Array linked list with free list: pool of NODES node indices kept as a used
// list and a free list sharing one next-link memory, plus two head registers.
//
// Channels: req carries one word (opcode, position, node_index); rsp returns one
// word (status, node) per request. A word moves when valid is high and stall low.
// req_stall is high whenever a request is in progress, so one request is worked
// at a time; a new request may be taken while the previous response still waits.
// Flow: a request rejected by the head checks goes straight to the done state.
// Others walk the list through the link memory at one node per cycle, then, if
// the walk finds its node, read the node being moved and write back one or two
// links through the single read port and write port of the link memory.
// Reset: the heads reset at once, then a clearing pass writes every entry i
// with i+1; req_stall stays high during the pass.
// A stalled response holds in the output register; the block finishes the next
// request's list work and waits in its last state until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_with_free_list #(
	parameter int NODES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire alfl_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output alfl_pkg::rsp_t      rsp
);

	import alfl_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam logic [LW-1:0] LINK_END = LW'(NODES);
	localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] clr_q, clr_d;
	logic [LW-1:0] used_head_q, used_head_d;
	logic [LW-1:0] free_head_q, free_head_d;
	logic [2:0]    op_q, op_d;
	logic [LW-1:0] idx_q, idx_d;
	logic [6:0]    cnt_q, cnt_d;
	logic          unb_q, unb_d;
	logic [IW-1:0] cur_q, cur_d;
	logic          cur_head_q, cur_head_d;
	logic [IW-1:0] prev_q, prev_d;
	logic          prev_head_q, prev_head_d;
	logic [LW-1:0] nxt_q, nxt_d;
	logic [IW-1:0] a_q, a_d;
	logic [LW-1:0] r_q, r_d;
	logic [2:0]    stat_q, stat_d;
	logic          rsp_valid_q, rsp_valid_d;
	rsp_t          rsp_q, rsp_d;

	logic          we;
	logic [IW-1:0] waddr;
	logic [LW-1:0] wdata;
	logic [IW-1:0] raddr;
	logic [LW-1:0] rdata;

	logic [LW-1:0] nxt;
	logic          idx_ok;
	logic          is_find;
	logic          is_insert;
	logic          adv;

	alfl_link_mem #(
		.DEPTH (NODES),
		.AW    (IW),
		.DW    (LW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_head_q <= LINK_END;
			free_head_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			used_head_q <= used_head_d;
			free_head_q <= free_head_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q        <= op_d;
		idx_q       <= idx_d;
		cnt_q       <= cnt_d;
		unb_q       <= unb_d;
		cur_q       <= cur_d;
		cur_head_q  <= cur_head_d;
		prev_q      <= prev_d;
		prev_head_q <= prev_head_d;
		nxt_q       <= nxt_d;
		a_q         <= a_d;
		r_q         <= r_d;
		stat_q      <= stat_d;
		rsp_q       <= rsp_d;
	end

	// link of the current cell: a head register or the memory read data
	assign nxt = cur_head_q ? ((op_q == OP_INS_IDX) ? free_head_q : used_head_q) : rdata;
	assign idx_ok = 32'(req.node_index) < 32'(NODES);
	assign is_find = (op_q == OP_INS_IDX) || (op_q == OP_REM_IDX);
	assign is_insert = (op_q == OP_INS_TAIL) || (op_q == OP_INS_POS);
	assign adv = (nxt != LINK_END) &&
		(is_find ? (nxt != idx_q) : (unb_q || (cnt_q != 7'd0)));

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		used_head_d = used_head_q;
		free_head_d = free_head_q;
		op_d        = op_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		unb_d       = unb_q;
		cur_d       = cur_q;
		cur_head_d  = cur_head_q;
		prev_d      = prev_q;
		prev_head_d = prev_head_q;
		nxt_d       = nxt_q;
		a_d         = a_q;
		r_d         = r_q;
		stat_d      = stat_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		we          = 1'b0;
		waddr       = a_q;
		wdata       = '0;
		raddr       = '0;

		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = LW'(clr_q) + LW'(1);
				clr_d = clr_q + IW'(1);
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					op_d        = req.opcode;
					idx_d       = LW'(req.node_index);
					cnt_d       = req.position;
					unb_d       = (req.opcode == OP_INS_TAIL) || (req.opcode == OP_REM_TAIL);
					cur_head_d  = 1'b1;
					prev_head_d = 1'b1;
					state_d     = S_WALK;
					case (req.opcode)
						OP_INS_TAIL, OP_INS_POS: begin
							if (free_head_q == LINK_END) begin
								stat_d  = ST_FULL;
								state_d = S_DONE;
							end
						end
						OP_INS_IDX, OP_REM_IDX: begin
							if (!idx_ok) begin
								stat_d  = ST_NOTFOUND;
								state_d = S_DONE;
							end
						end
						OP_REM_TAIL, OP_REM_POS: begin
							if (used_head_q == LINK_END) begin
								stat_d  = ST_EMPTY;
								state_d = S_DONE;
							end
						end
						default: begin
							stat_d  = ST_BADPOS;
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_WALK: begin
				nxt_d = nxt;
				if (adv) begin
					cur_d       = nxt[IW-1:0];
					cur_head_d  = 1'b0;
					prev_d      = cur_q;
					prev_head_d = cur_head_q;
					cnt_d       = cnt_q - 7'd1;
					raddr       = nxt[IW-1:0];
				end else begin
					state_d = S_WRITE1;
					case (op_q)
						OP_INS_TAIL, OP_INS_POS: begin
							a_d   = free_head_q[IW-1:0];
							raddr = free_head_q[IW-1:0];
						end
						OP_INS_IDX, OP_REM_IDX: begin
							a_d   = nxt[IW-1:0];
							raddr = nxt[IW-1:0];
							if (nxt != idx_q) begin
								stat_d  = ST_NOTFOUND;
								state_d = S_DONE;
							end
						end
						OP_REM_TAIL: begin
							// current cell is the tail; unlink it from its predecessor
							cur_d      = prev_q;
							cur_head_d = prev_head_q;
							nxt_d      = LW'(cur_q);
							a_d        = cur_q;
							raddr      = cur_q;
						end
						default: begin
							a_d   = nxt[IW-1:0];
							raddr = nxt[IW-1:0];
							if (nxt == LINK_END) begin
								stat_d  = ST_BADPOS;
								state_d = S_DONE;
							end
						end
					endcase
				end
			end
			S_WRITE1: begin
				we    = 1'b1;
				waddr = a_q;
				r_d   = rdata;
				stat_d = ST_OK;
				if (is_insert) begin
					wdata       = nxt_q;
					free_head_d = rdata;
					if (cur_head_q) begin
						used_head_d = LW'(a_q);
					end
				end else if (op_q == OP_INS_IDX) begin
					wdata       = used_head_q;
					used_head_d = LW'(a_q);
					if (cur_head_q) begin
						free_head_d = rdata;
					end
				end else begin
					wdata       = free_head_q;
					free_head_d = LW'(a_q);
					if (cur_head_q) begin
						used_head_d = rdata;
					end
				end
				state_d = cur_head_q ? S_DONE : S_WRITE2;
			end
			S_WRITE2: begin
				we      = 1'b1;
				waddr   = cur_q;
				wdata   = is_insert ? LW'(a_q) : r_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_d = 1'b1;
					rsp_d.status = stat_q;
					rsp_d.node   = (stat_q == ST_OK) ? 6'(a_q) : 6'd0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
